// File: sv/rgbmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbmf_pkg: shared types for the RGB 3x3 median filter
// Pixel, column and window types, the input and result items, and the
// window job that travels from the column store to the channel lanes.
// ----------------------------------------------------------------------------
package rgbmf_pkg;

  localparam int unsigned PIXEL_BITS = 8;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // One column of three pixels, entry 0 is the top row.
  typedef pix_t [2:0] col_t;

  // One 3x3 window of a channel, entry 0 is the oldest column.
  typedef col_t [2:0] win_t;

  typedef struct packed {
    pix_t red_top;
    pix_t red_middle;
    pix_t red_bottom;
    pix_t green_top;
    pix_t green_middle;
    pix_t green_bottom;
    pix_t blue_top;
    pix_t blue_middle;
    pix_t blue_bottom;
    logic row_first;
    logic row_last;
  } in_item_t;

  typedef struct packed {
    pix_t red_median;
    pix_t green_median;
    pix_t blue_median;
    logic last_of_run;
  } out_item_t;

  // A window to be reduced to its medians, one per channel.
  typedef struct packed {
    logic valid;
    logic last;
    win_t red;
    win_t green;
    win_t blue;
  } job_t;

endpackage

// File: sv/rgbmf_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbmf_window: column store and window sequencer
// Holds the two previous columns of each channel, handles row start and row
// end replication, and issues at most one registered window job per cycle while adv_i is high.
// ----------------------------------------------------------------------------
module rgbmf_window import rgbmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  input  logic     adv_i,
  output job_t     job_o
);

  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  col_t [1:0] red_q, red_d;
  col_t [1:0] green_q, green_d;
  col_t [1:0] blue_q, blue_d;
  logic [1:0] held_q, held_d;
  logic       pending_q, pending_d;
  job_t       job_q, job_d;

  col_t r_in, g_in, b_in;
  logic accept;
  logic start;

  assign r_in = {in_i.red_bottom, in_i.red_middle, in_i.red_top};
  assign g_in = {in_i.green_bottom, in_i.green_middle, in_i.green_top};
  assign b_in = {in_i.blue_bottom, in_i.blue_middle, in_i.blue_top};

  // While the flush window of a row end is pending, no new item is taken.
  assign in_stall_o = pending_q || !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = in_i.row_first || (held_q == HeldNone);

  always_comb begin
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    held_d    = held_q;
    pending_d = pending_q;
    job_d     = '0;
    if (pending_q) begin
      // Right border: the newest column is repeated.
      job_d.valid = 1'b1;
      job_d.last  = 1'b1;
      job_d.red   = {red_q[1], red_q[1], red_q[0]};
      job_d.green = {green_q[1], green_q[1], green_q[0]};
      job_d.blue  = {blue_q[1], blue_q[1], blue_q[0]};
      pending_d   = 1'b0;
    end else if (accept) begin
      if (start) begin
        // Left border: the first column fills both held columns.
        red_d   = {r_in, r_in};
        green_d = {g_in, g_in};
        blue_d  = {b_in, b_in};
        if (in_i.row_last) begin
          job_d.valid = 1'b1;
          job_d.last  = 1'b1;
          job_d.red   = {r_in, r_in, r_in};
          job_d.green = {g_in, g_in, g_in};
          job_d.blue  = {b_in, b_in, b_in};
          held_d      = HeldNone;
        end else begin
          held_d = HeldOne;
        end
      end else begin
        job_d.valid = 1'b1;
        job_d.last  = !in_i.row_last;
        job_d.red   = {r_in, red_q[1], red_q[0]};
        job_d.green = {g_in, green_q[1], green_q[0]};
        job_d.blue  = {b_in, blue_q[1], blue_q[0]};
        red_d       = {r_in, red_q[1]};
        green_d     = {g_in, green_q[1]};
        blue_d      = {b_in, blue_q[1]};
        if (in_i.row_last) begin
          pending_d = 1'b1;
          held_d    = HeldNone;
        end else begin
          held_d = HeldTwo;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
      held_q    <= HeldNone;
      pending_q <= 1'b0;
      job_q     <= '0;
    end else if (adv_i) begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      held_q    <= held_d;
      pending_q <= pending_d;
      job_q     <= job_d;
    end
  end

  assign job_o = job_q;

endmodule

// File: sv/rgbmf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbmf_lane: median of nine for one channel
// Two register stages: columns are sorted, then the maximum of the lows,
// the median of the middles and the minimum of the highs are kept. The
// median of those three is the window median.
// ----------------------------------------------------------------------------
module rgbmf_lane import rgbmf_pkg::*; (
  input  logic clk_i,
  input  logic adv_i,
  input  win_t win_i,
  output pix_t median_o
);

  function automatic col_t sort3(input col_t c);
    col_t s;
    pix_t t;
    s = c;
    if (s[0] > s[1]) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    if (s[1] > s[2]) begin
      t = s[1]; s[1] = s[2]; s[2] = t;
    end
    if (s[0] > s[1]) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    return s;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    pix_t lo;
    pix_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  win_t s1_q;
  col_t s2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        s1_q[c] <= sort3(win_i[c]);
      end
      s2_q[0] <= max3(s1_q[0][0], s1_q[1][0], s1_q[2][0]);
      s2_q[1] <= med3(s1_q[0][1], s1_q[1][1], s1_q[2][1]);
      s2_q[2] <= min3(s1_q[0][2], s1_q[1][2], s1_q[2][2]);
    end
  end

  assign median_o = med3(s2_q[0], s2_q[1], s2_q[2]);

endmodule

// File: sv/rgb_median_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3: streaming 3x3 median filter on RGB columns
// One item is a column of three pixels per channel; results are the
// per-channel medians of the 3x3 window with horizontal edge replication.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   in_i  (in_item_t)
//   output   out        out_valid_o / out_stall_i out_o (out_item_t)
//
// An item is accepted at a clock edge where valid is high and stall is low.
// The block takes one column per cycle while the output does not stall; a
// column that ends an open row yields two results and holds the input off
// while the second, the flush window, is issued. Each result passes, in
// order, the window job register, column sort stage, rank stage and output register.
// A stalled output freezes the whole pipeline, and the input stalls too.
// Reset is asynchronous and active low; it empties the pipeline and closes
// any open row, so the next column starts a new row.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3 import rgbmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  // The pipeline moves as one whenever the output register can take a
  // result. Bubbles are carried along with their stage valid bits.
  logic adv;
  job_t job;

  // Valid and last flags that travel beside the lane stages.
  logic v1_q, v2_q;
  logic l1_q, l2_q;

  pix_t red_med, green_med, blue_med;

  logic      out_valid_q;
  out_item_t out_q;

  assign adv = !(out_valid_q && out_stall_i);

  rgbmf_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .adv_i      (adv),
    .job_o      (job)
  );

  // Three channel lanes reduce their windows side by side.
  rgbmf_lane u_lane_red (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .win_i    (job.red),
    .median_o (red_med)
  );

  rgbmf_lane u_lane_green (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .win_i    (job.green),
    .median_o (green_med)
  );

  rgbmf_lane u_lane_blue (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .win_i    (job.blue),
    .median_o (blue_med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= job.valid;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // The merging stage: the three lane medians and the run flag form one
  // result item in the output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q              <= job.last;
      l2_q              <= l1_q;
      out_q.red_median   <= red_med;
      out_q.green_median <= green_med;
      out_q.blue_median  <= blue_med;
      out_q.last_of_run  <= l2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: sv/rgbmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbmf_checker: port-level checks for the RGB 3x3 median filter
// Watches the handshakes and the run flag of the result items.
// ----------------------------------------------------------------------------
module rgbmf_checker import rgbmf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  // The first result of a row-end pair is followed at once by the second.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_o.last_of_run |=> out_valid_o && out_o.last_of_run)
    else $error("row-end pair broken");

  // Without a recent acceptance or an output stall the input is never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_valid_i && !in_stall_o) && !$past(out_valid_o && out_stall_i) &&
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input stalled without cause");

endmodule

bind rgb_median_filter_3x3 rgbmf_checker u_rgbmf_checker (.*);
